/* hdl/aes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CBC package
// Shared types, register codes, substitution tables and helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int RK_ROWS   = 15;   // one 128-bit round key per row
  localparam int RK_ADDR_W = 4;
  localparam int NR_W      = 4;

  typedef struct packed {
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [4:0]  valid_bytes;
    logic        first_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic [4:0]  result_bytes;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_KEY0     = 3'd0,
    CFG_KEY1     = 3'd1,
    CFG_KEY2     = 3'd2,
    CFG_KEY3     = 3'd3,
    CFG_KEY_SIZE = 3'd4,
    CFG_DIR      = 3'd5,
    CFG_IV_HI    = 3'd6,
    CFG_IV_LO    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_size_e;

  typedef struct packed {
    logic                 en;
    logic [RK_ADDR_W-1:0] addr;
    logic [127:0]         data;
  } kx_wr_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // The unused key size code selects the 256-bit schedule.
  function automatic logic [NR_W-1:0] num_rounds(input logic [1:0] ks);
    logic [NR_W-1:0] nr;
    case (ks)
      KEY_128: nr = 4'd10;
      KEY_192: nr = 4'd12;
      default: nr = 4'd14;
    endcase
    return nr;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Keeps the leading vb bytes; byte 0 sits in the top bits.
  function automatic logic [127:0] byte_mask(input logic [4:0] vb);
    logic [127:0] m;
    m = '0;
    for (int n = 0; n < 16; n++) begin
      m[127-8*n -: 8] = (5'(n) < vb) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

/* hdl/aes_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/aes_key_exp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES key expansion
// Produces one schedule word per cycle and writes each finished round key
// as one 128-bit row of the round key memory.
// ----------------------------------------------------------------------------
module aes_key_exp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [255:0]         key_i,
  input  logic [1:0]           key_size_i,
  output logic                 busy_o,
  output aes_pkg::kx_wr_t      wr_o
);
  import aes_pkg::*;

  logic            busy_q;
  logic [5:0]      idx_q;
  logic [2:0]      phase_q;
  logic [7:0]      rc_q;
  logic [31:0]     hist_q [8];
  logic [NR_W-1:0] nr;
  logic [3:0]      nk;
  logic [2:0]      nk_last;
  logic [31:0]     key_word;
  logic [31:0]     tmp;
  logic [31:0]     word;
  logic            from_key;
  logic            last_word;

  assign nr      = num_rounds(key_size_i);
  assign nk      = nr - 4'd6;
  assign nk_last = nk[2:0] - 3'd1;

  always_comb begin
    key_word  = key_i[255 - 32*idx_q[2:0] -: 32];
    from_key  = idx_q < {2'b00, nk};
    tmp       = hist_q[0];
    if (phase_q == 3'd0) begin
      tmp = sub_word({hist_q[0][23:0], hist_q[0][31:24]}) ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && phase_q == 3'd4) begin
      tmp = sub_word(hist_q[0]);
    end
    word      = from_key ? key_word : (hist_q[nk_last] ^ tmp);
    last_word = idx_q == {nr, 2'b11};
  end

  assign busy_o  = busy_q;
  assign wr_o.en   = busy_q && (idx_q[1:0] == 2'b11);
  assign wr_o.addr = idx_q[5:2];
  assign wr_o.data = {hist_q[2], hist_q[1], hist_q[0], word};

  // Reset starts an expansion of the cleared key straight away.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      idx_q   <= '0;
      phase_q <= '0;
      rc_q    <= 8'h01;
      for (int k = 0; k < 8; k++) begin
        hist_q[k] <= '0;
      end
    end else if (start_i) begin
      busy_q  <= 1'b1;
      idx_q   <= '0;
      phase_q <= '0;
      rc_q    <= 8'h01;
    end else if (busy_q) begin
      hist_q[0] <= word;
      for (int k = 1; k < 8; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
      idx_q   <= idx_q + 6'd1;
      phase_q <= (phase_q == nk_last) ? 3'd0 : phase_q + 3'd1;
      if (!from_key && phase_q == 3'd0) begin
        rc_q <= {rc_q[6:0], 1'b0} ^ (rc_q[7] ? 8'h1b : 8'h00);
      end
      if (last_word) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

/* hdl/aes_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round
// One forward or inverse cipher round on the 128-bit state.
// ----------------------------------------------------------------------------
module aes_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         decrypt_i,
  input  logic         final_i,
  output logic [127:0] state_o
);
  import aes_pkg::*;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] b [4];
    logic [7:0] x2, x4, x8;
    for (int r = 0; r < 4; r++) begin
      a[r] = col[31-8*r -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        b[r] = 8'h00;
        for (int k = 0; k < 4; k++) begin
          x2 = xt(a[(r+k) & 3]);
          x4 = xt(x2);
          x8 = xt(x4);
          case (k)
            0:       b[r] = b[r] ^ x8 ^ x4 ^ x2;
            1:       b[r] = b[r] ^ x8 ^ x2 ^ a[(r+k) & 3];
            2:       b[r] = b[r] ^ x8 ^ x4 ^ a[(r+k) & 3];
            default: b[r] = b[r] ^ x8 ^ a[(r+k) & 3];
          endcase
        end
      end else begin
        b[r] = xt(a[r]) ^ xt(a[(r+1) & 3]) ^ a[(r+1) & 3] ^ a[(r+2) & 3] ^ a[(r+3) & 3];
      end
    end
    return {b[0], b[1], b[2], b[3]};
  endfunction

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [127:0] shifted;
  logic [127:0] mixed;
  logic [127:0] keyed;

  always_comb begin
    for (int n = 0; n < 16; n++) begin
      s[n] = state_i[127-8*n -: 8];
    end
    // Row r moves left by r columns when encrypting, right when decrypting.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (decrypt_i) begin
          t[4*((c+r) & 3) + r] = INV_SBOX[s[4*c + r]];
        end else begin
          t[4*c + r] = SBOX[s[4*((c+r) & 3) + r]];
        end
      end
    end
    for (int n = 0; n < 16; n++) begin
      shifted[127-8*n -: 8] = t[n];
    end
    if (decrypt_i) begin
      keyed = shifted ^ rkey_i;
      for (int c = 0; c < 4; c++) begin
        mixed[127-32*c -: 32] = mix_col(keyed[127-32*c -: 32], 1'b1);
      end
      state_o = final_i ? keyed : mixed;
    end else begin
      for (int c = 0; c < 4; c++) begin
        mixed[127-32*c -: 32] = mix_col(shifted[127-32*c -: 32], 1'b0);
      end
      keyed   = (final_i ? shifted : mixed) ^ rkey_i;
      state_o = keyed;
    end
  end

endmodule

/* hdl/aes_cbc_block_cipher.sv */
`timescale 1ns / 1ps
// Each block passes through the load step, then one round per cycle against the round
// key memory read port for 10, 12 or 14 rounds, then the done step, which waits while
// an earlier result is still held. One block is in flight at a time, so no new block
// is taken until the last one has finished. After reset and after each key or key
// size write the schedule is rebuilt with input ready low.
// ----------------------------------------------------------------------------
// AES CBC block cipher
// CBC encrypt and decrypt with on-chip key expansion into a round key RAM.
// ----------------------------------------------------------------------------
module aes_cbc_block_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aes_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output aes_pkg::out_item_t out_data_o
);
  import aes_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [63:0]     key_q [4];
  logic [1:0]      ks_q;
  logic            dir_q;
  logic [127:0]    iv_q;
  logic [127:0]    chain_q;
  logic [127:0]    st_q;
  logic [127:0]    blk_q;
  logic [127:0]    cv_q;
  logic [4:0]      vb_q;
  logic [NR_W-1:0] rnd_q;
  logic [NR_W-1:0] rnd_d;
  logic            out_valid_q;
  out_item_t       out_q;

  logic [NR_W-1:0] nr;
  logic            kx_start;
  logic            kx_busy;
  kx_wr_t          kx_wr;
  logic [127:0]    rk_data;
  logic [127:0]    rnd_out;
  logic            last_round;
  logic            accept;
  logic [4:0]      vb_eff;
  logic [127:0]    blk_in;
  logic [127:0]    cv_in;
  logic [127:0]    pre;
  logic [127:0]    dec_res;

  assign nr       = num_rounds(ks_q);
  assign kx_start = cfg_we_i && (cfg_idx_i inside {CFG_KEY0, CFG_KEY1, CFG_KEY2,
                                                   CFG_KEY3, CFG_KEY_SIZE});

  aes_key_exp u_key_exp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kx_start),
    .key_i      ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .key_size_i (ks_q),
    .busy_o     (kx_busy),
    .wr_o       (kx_wr)
  );

  aes_ram #(
    .WIDTH (128),
    .DEPTH (RK_ROWS)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (kx_wr.en),
    .waddr_i (kx_wr.addr),
    .wdata_i (kx_wr.data),
    .raddr_i (rnd_d),
    .rdata_o (rk_data)
  );

  assign last_round = dir_q ? (rnd_q == '0) : (rnd_q == nr);

  aes_round u_round (
    .state_i   (st_q),
    .rkey_i    (rk_data),
    .decrypt_i (dir_q),
    .final_i   (last_round),
    .state_o   (rnd_out)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && !kx_busy;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    vb_eff  = (in_data_i.valid_bytes > 5'd16) ? 5'd16 : in_data_i.valid_bytes;
    blk_in  = {in_data_i.block_hi, in_data_i.block_lo};
    cv_in   = in_data_i.first_block ? iv_q : chain_q;
    pre     = dir_q ? blk_in : ((blk_in & byte_mask(vb_eff)) ^ cv_in);
    dec_res = (st_q ^ cv_q) & byte_mask(vb_q);
  end

  // Round key row to read this cycle; it is used in the next one.
  always_comb begin
    case (state_q)
      ST_IDLE:  rnd_d = dir_q ? nr : '0;
      ST_LOAD:  rnd_d = dir_q ? nr - 4'd1 : 4'd1;
      ST_ROUND: rnd_d = last_round ? rnd_q : (dir_q ? rnd_q - 4'd1 : rnd_q + 4'd1);
      default:  rnd_d = rnd_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= '0;
      end
      ks_q        <= '0;
      dir_q       <= 1'b0;
      iv_q        <= '0;
      chain_q     <= '0;
      st_q        <= '0;
      blk_q       <= '0;
      cv_q        <= '0;
      vb_q        <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_KEY0:     key_q[0]      <= cfg_data_i;
          CFG_KEY1:     key_q[1]      <= cfg_data_i;
          CFG_KEY2:     key_q[2]      <= cfg_data_i;
          CFG_KEY3:     key_q[3]      <= cfg_data_i;
          CFG_KEY_SIZE: ks_q          <= cfg_data_i[1:0];
          CFG_DIR:      dir_q         <= cfg_data_i[0];
          CFG_IV_HI:    iv_q[127:64]  <= cfg_data_i;
          CFG_IV_LO:    iv_q[63:0]    <= cfg_data_i;
          default:      ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          // A transaction with no valid bytes is consumed without effect.
          if (accept && in_data_i.valid_bytes != '0) begin
            st_q    <= pre;
            blk_q   <= blk_in;
            cv_q    <= cv_in;
            vb_q    <= vb_eff;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          st_q    <= st_q ^ rk_data;
          rnd_q   <= rnd_d;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          st_q  <= rnd_out;
          rnd_q <= rnd_d;
          if (last_round) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (dir_q) begin
              out_q   <= {dec_res, vb_q};
              chain_q <= blk_q;
            end else begin
              out_q   <= {st_q, 5'd16};
              chain_q <= st_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_while_expanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kx_busy |-> !in_ready_o)
    else $error("input accepted while the key schedule is being rebuilt");

  a_round_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (rnd_q <= nr))
    else $error("round counter beyond the round count");

  a_key_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kx_wr.en |-> (kx_wr.addr < 4'(RK_ROWS)))
    else $error("round key row written beyond the memory");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_q.result_bytes != 5'd0 && out_q.result_bytes <= 5'd16))
    else $error("result byte count out of range");

  a_chain_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished block not presented");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CBC block cipher testbench
// The testbench runs directed and random blocks through several key sizes,
// both directions and assorted IVs. Random idling and long stalls are placed
// on both sides, and every result is checked against an in-bench AES CBC
// predictor.
// ----------------------------------------------------------------------------
module tb;
  import aes_pkg::*;

  localparam int LIMIT = 300000;
  localparam int SETTLE = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_item_t out_data_o;

  aes_cbc_block_cipher dut (.*);

  // Predictor state.
  logic [63:0] key_w [4];
  logic [1:0] key_sz;
  logic decrypt;
  logic [127:0] iv;
  logic [127:0] chain;
  logic [31:0] sched [60];
  logic [7:0] fwd_sb [256];
  logic [7:0] inv_sb [256];

  in_item_t pending_blocks[$];
  out_item_t expected_blocks[$];
  int cycle_cnt;
  bit failed;
  bit taken;
  bit hold_sender;
  bit long_stall_req;
  int burst_left, gap_left;
  int stall_left, rx_mode, rx_phase;

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xt(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  function automatic int round_count();
    return key_sz == KEY_128 ? 10 : (key_sz == KEY_192 ? 12 : 14);
  endfunction

  function automatic logic [31:0] sub_bytes32(logic [31:0] w);
    return {fwd_sb[w[31:24]], fwd_sb[w[23:16]], fwd_sb[w[15:8]], fwd_sb[w[7:0]]};
  endfunction

  function automatic void rebuild_schedule();
    int nr, nk;
    logic [31:0] t;
    logic [7:0] rc;
    nr = round_count();
    nk = nr - 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++) sched[i] = i[0] ? key_w[i>>1][31:0] : key_w[i>>1][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sub_bytes32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xt(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_bytes32(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endfunction

  function automatic logic [127:0] rkey(int r);
    return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
  endfunction

  function automatic logic [127:0] mix(logic [127:0] s, bit inverse);
    logic [7:0] a [4];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = inverse ?
          gmul(a[r], 8'd14) ^ gmul(a[(r+1)&3], 8'd11) ^
          gmul(a[(r+2)&3], 8'd13) ^ gmul(a[(r+3)&3], 8'd9) :
          gmul(a[r], 8'd2) ^ gmul(a[(r+1)&3], 8'd3) ^ a[(r+2)&3] ^ a[(r+3)&3];
    end
    return o;
  endfunction

  function automatic logic [127:0] aes_forward(logic [127:0] s);
    logic [127:0] t;
    int nr;
    nr = round_count();
    s ^= rkey(0);
    for (int rnd = 1; rnd <= nr; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127-8*(4*c+r) -: 8] = fwd_sb[s[127-8*(4*((c+r)&3)+r) -: 8]];
      s = (rnd != nr) ? mix(t, 1'b0) : t;
      s ^= rkey(rnd);
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_inverse(logic [127:0] s);
    logic [127:0] t;
    int nr;
    nr = round_count();
    s ^= rkey(nr);
    for (int rnd = nr - 1; rnd >= 0; rnd--) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127-8*(4*((c+r)&3)+r) -: 8] = inv_sb[s[127-8*(4*c+r) -: 8]];
      s = t ^ rkey(rnd);
      if (rnd != 0) s = mix(s, 1'b1);
    end
    return s;
  endfunction

  // Advances the chaining value and returns 1 when the block yields a result.
  function automatic bit cbc_step(in_item_t it, output out_item_t res);
    int vb;
    logic [127:0] keep, blk;
    vb = it.valid_bytes;
    res = '0;
    if (vb == 0) return 0;
    if (vb > 16) vb = 16;
    keep = '0;
    for (int n = 0; n < vb; n++) keep[127-8*n -: 8] = 8'hff;
    if (it.first_block) chain = iv;
    blk = {it.block_hi, it.block_lo};
    if (!decrypt) begin
      chain = aes_forward((blk & keep) ^ chain);
      {res.result_hi, res.result_lo} = chain;
      res.result_bytes = 5'd16;
    end else begin
      {res.result_hi, res.result_lo} = (aes_inverse(blk) ^ chain) & keep;
      chain = blk;
      res.result_bytes = 5'(vb);
    end
    return 1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: bursts of transactions separated by random gaps.
  always @(negedge clk_i) begin
    if (!in_valid_i || taken) begin
      if (gap_left > 0 || hold_sender || pending_blocks.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_data_i <= pending_blocks.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (long_stall_req && stall_left == 0) begin
      stall_left <= 400;
      long_stall_req <= 1'b0;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predicts on each accepted block and checks each accepted result.
  always @(posedge clk_i) begin
    out_item_t pred, want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst_ni) begin
      taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o && cbc_step(in_data_i, pred))
        expected_blocks.push_back(pred);
      if (out_valid_o && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          $error("result transaction with no block outstanding");
          failed = 1'b1;
        end else begin
          want = expected_blocks.pop_front();
          if (out_data_o.result_hi !== want.result_hi) begin
            $error("result_hi expected %h actual %h", want.result_hi, out_data_o.result_hi);
            failed = 1'b1;
          end
          if (out_data_o.result_lo !== want.result_lo) begin
            $error("result_lo expected %h actual %h", want.result_lo, out_data_o.result_lo);
            failed = 1'b1;
          end
          if (out_data_o.result_bytes !== want.result_bytes) begin
            $error("result_bytes expected %0d actual %0d", want.result_bytes,
                   out_data_o.result_bytes);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic cfg_write(cfg_reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_w[idx] = val;
      CFG_KEY_SIZE: key_sz = val[1:0];
      CFG_DIR: decrypt = val[0];
      CFG_IV_HI: iv[127:64] = val;
      default: iv[63:0] = val;
    endcase
    if (idx <= CFG_KEY_SIZE) rebuild_schedule();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                       logic [1:0] ks, bit dir, logic [127:0] vec);
    cfg_write(CFG_KEY0, k0);
    cfg_write(CFG_KEY1, k1);
    cfg_write(CFG_KEY2, k2);
    cfg_write(CFG_KEY3, k3);
    cfg_write(CFG_KEY_SIZE, {62'h0, ks});
    cfg_write(CFG_DIR, {63'h0, dir});
    cfg_write(CFG_IV_HI, vec[127:64]);
    cfg_write(CFG_IV_LO, vec[63:0]);
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0 || in_valid_i || expected_blocks.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_block(logic [63:0] hi, logic [63:0] lo, logic [4:0] vb, bit first);
    in_item_t it;
    it.block_hi = hi;
    it.block_lo = lo;
    it.valid_bytes = vb;
    it.first_block = first;
    pending_blocks.push_back(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // One well-formed message: IV reload, full blocks, and sometimes a short tail.
  task automatic push_message(output int n);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      push_block(rand64(), rand64(),
                 (i == n - 1 && $urandom_range(0, 2) == 0) ? 5'($urandom_range(1, 15)) : 5'd16,
                 i == 0);
  endtask

  initial begin
    int sent, n;
    logic [7:0] x;
    for (int a = 0; a < 256; a++) begin
      x = 8'h00;
      for (int b = 1; b < 256; b++) if (gmul(8'(a), 8'(b)) == 8'h01) x = 8'(b);
      fwd_sb[a] = x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4) ^ 8'h63;
    end
    for (int a = 0; a < 256; a++) inv_sb[fwd_sb[a]] = 8'(a);
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    key_sz = KEY_128;
    decrypt = 1'b0;
    iv = '0;
    chain = '0;
    rebuild_schedule();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_KEY0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cycle_cnt = 0;
    failed = 1'b0;
    taken = 1'b0;
    hold_sender = 1'b0;
    long_stall_req = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_left = 0;
    rx_mode = 0;
    rx_phase = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: all-zero key, encrypting, chaining from zero.
    push_block('0, '0, 5'd16, 1'b0);
    push_block('1, '1, 5'd16, 1'b0);
    push_block('1, '1, 5'd1, 1'b1);
    push_block('1, '1, 5'd0, 1'b1);
    push_block('1, '1, 5'd31, 1'b0);
    drain();
    setup(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, KEY_128, 1'b0, '0);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b1);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd15, 1'b0);
    drain();
    setup('1, '1, '1, '1, KEY_192, 1'b1, '1);
    push_block('1, '0, 5'd16, 1'b1);
    push_block('0, '1, 5'd15, 1'b0);
    push_block('1, '1, 5'd17, 1'b0);
    push_block(rand64(), rand64(), 5'd0, 1'b0);
    push_block(rand64(), rand64(), 5'd1, 1'b1);
    drain();
    setup(rand64(), rand64(), rand64(), rand64(), KEY_256, 1'b0, '1);
    push_block(rand64(), rand64(), 5'd16, 1'b1);
    push_block(rand64(), rand64(), 5'd8, 1'b0);
    drain();
    // The unused key size code must behave as a 256-bit key.
    setup(rand64(), rand64(), rand64(), rand64(), 2'd3, 1'b1, {rand64(), rand64()});
    push_block(rand64(), rand64(), 5'd16, 1'b1);
    push_block(rand64(), rand64(), 5'd16, 1'b0);
    push_block(rand64(), rand64(), 5'd3, 1'b0);
    drain();

    sent = 0;
    for (int ph = 0; sent < 400; ph++) begin
      setup(rand64(), rand64(), rand64(), rand64(), 2'($urandom_range(0, 3)),
            1'($urandom_range(0, 1)), {rand64(), rand64()});
      for (int m = 0; m < 8; m++) begin
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            push_block(rand64(), rand64(), 5'($urandom_range(0, 31)),
                       1'($urandom_range(0, 1)));
        end else begin
          push_message(n);
        end
        sent += n;
        if (ph == 1 && m == 2) begin
          long_stall_req = 1'b1;
          for (int i = 0; i < 30; i++) push_block(rand64(), rand64(), 5'd16, 1'b0);
          sent += 30;
        end
        if (ph == 2 && m == 4) begin
          // Sender holds back until every outstanding result has come out.
          hold_sender = 1'b1;
          while (expected_blocks.size() != 0 || in_valid_i) @(posedge clk_i);
          hold_sender = 1'b0;
        end
      end
      drain();
    end

    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
